// ===== design/apa_pkg.sv =====
`timescale 1ns / 1ps
// Address pool allocator: shared constants, status and register codes, helpers.
// No dependencies.
package apa_pkg;

    // Pool geometry
    localparam int MAX_HOST_BITS = 8;
    localparam int POOL_DEPTH    = 1 << MAX_HOST_BITS;
    localparam int WORD_BITS     = 16;
    localparam int NUM_WORDS     = POOL_DEPTH / WORD_BITS;
    localparam int BIT_IDX_W     = $clog2(WORD_BITS);
    localparam int WORD_IDX_W    = $clog2(NUM_WORDS);
    localparam int COUNT_W       = MAX_HOST_BITS + 1;
    localparam int HB_W          = 4;

    typedef logic [WORD_BITS-1:0] word_t;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
    localparam logic [1:0] ST_RESERVED = 2'd3;

    // Input item kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_PREFIX    = 2'd0;
    localparam logic [1:0] CFG_HOST_BITS = 2'd1;

    // Index of the lowest set bit (zero when none is set)
    function automatic logic [BIT_IDX_W-1:0] lowest_one(input word_t v);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i])
            begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== design/apa_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module apa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wa,
    input  logic [WIDTH-1:0]         wd,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] ra,
    output logic [WIDTH-1:0]         rd
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds when not reading
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd <= mem[ra];
        end
    end

endmodule

// ===== design/address_pool_allocator_core.sv =====
`timescale 1ns / 1ps
// Address pool allocator: used-map in a RAM of 16-bit words plus a per-word full flag.
// Depends on apa_pkg and apa_ram.
// out_valid rises after the S_CHK1 and S_FIN states, or after S_CHK1, S_CHK2 and S_FIN
// when the search has to move to another word (one extra RAM read); S_FIN waits while
// the output is stalled. One item at a time, set by the read-modify-write of the used-map RAM.
// Reset: the used-map is rebuilt by a pass over all 16 RAM words (one word a cycle),
// during which no item is taken; writing host_bits starts the same pass again.
module address_pool_allocator_core
    import apa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [31:0] address,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] assigned_address,
    output logic [1:0]  status,
    output logic [COUNT_W-1:0] free_count
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CHK1 = 3'd2;
    localparam logic [2:0] S_CHK2 = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic [COUNT_W-1:0] FREE_RESET = COUNT_W'(POOL_DEPTH - 3);

    logic [2:0]               state_reg, state_next;
    logic [WORD_IDX_W-1:0]    init_cnt_reg, init_cnt_next;
    logic                     kind_reg, kind_next;
    logic [MAX_HOST_BITS-1:0] host_reg, host_next;
    logic                     rsvd_reg, rsvd_next;
    logic [WORD_IDX_W-1:0]    word2_reg, word2_next;
    word_t                    summary_reg, summary_next;
    logic [COUNT_W-1:0]       free_total_reg, free_total_next;
    logic [31:0]              prefix_reg, prefix_next;
    logic [HB_W-1:0]          host_bits_reg, host_bits_next;

    // pending write-back and result held until the output slot is free
    logic                     pend_we_reg, pend_we_next;
    logic [WORD_IDX_W-1:0]    pend_word_reg, pend_word_next;
    word_t                    pend_data_reg, pend_data_next;
    logic                     pend_inc_reg, pend_inc_next;
    logic                     pend_dec_reg, pend_dec_next;
    logic [1:0]               pend_status_reg, pend_status_next;
    logic [MAX_HOST_BITS-1:0] pend_host_reg, pend_host_next;

    logic                     out_valid_reg, out_valid_next;
    logic [31:0]              out_addr_reg, out_addr_next;
    logic [1:0]               out_status_reg, out_status_next;
    logic [COUNT_W-1:0]       out_free_reg, out_free_next;

    // RAM port signals
    logic                     ram_we, ram_re;
    logic [WORD_IDX_W-1:0]    ram_wa, ram_ra;
    word_t                    ram_wd, ram_rd;

    logic [HB_W-1:0]          eff_bits;
    logic [COUNT_W-1:0]       pool_size;
    logic [MAX_HOST_BITS-1:0] host_mask;
    logic [MAX_HOST_BITS-1:0] in_host;
    logic                     in_rsvd;
    logic                     in_fire, fin_fire;
    word_t                    init_word;
    word_t                    below_mask, avail1, free_words, up_words, cand_words;
    logic [BIT_IDX_W-1:0]     bit1, bit2;
    logic [WORD_IDX_W-1:0]    pick_word;
    logic [COUNT_W-1:0]       free_after;

    apa_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(NUM_WORDS)
    ) u_used_map (
        .clk(clk),
        .we (ram_we),
        .wa (ram_wa),
        .wd (ram_wd),
        .re (ram_re),
        .ra (ram_ra),
        .rd (ram_rd)
    );

    // Pool size from the saturated host bit count
    always_comb
    begin
        if (host_bits_reg < HB_W'(2))
        begin
            eff_bits = HB_W'(2);
        end
        else if (host_bits_reg > HB_W'(MAX_HOST_BITS))
        begin
            eff_bits = HB_W'(MAX_HOST_BITS);
        end
        else
        begin
            eff_bits = host_bits_reg;
        end
        pool_size = COUNT_W'(1) << eff_bits;
        host_mask = MAX_HOST_BITS'(pool_size - COUNT_W'(1));
    end

    // Incoming host and its reserved check
    assign in_host = address[MAX_HOST_BITS-1:0] & host_mask;
    assign in_rsvd = (in_host == '0)
                  || ({1'b0, in_host} == pool_size - COUNT_W'(1))
                  || ({1'b0, in_host} == pool_size - COUNT_W'(2));

    // Word pattern written by the init pass: reserved and out-of-pool hosts marked used
    always_comb
    begin
        logic [MAX_HOST_BITS-1:0] h;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            h = {init_cnt_reg, BIT_IDX_W'(j)};
            init_word[j] = (h == '0)
                        || ({1'b0, h} >= pool_size)
                        || ({1'b0, h} == pool_size - COUNT_W'(1))
                        || ({1'b0, h} == pool_size - COUNT_W'(2));
        end
    end

    // Search over the first word read, then over the full flags
    always_comb
    begin
        below_mask = (word_t'(1) << host_reg[BIT_IDX_W-1:0]) - word_t'(1);
        avail1     = ~(ram_rd | below_mask);
        bit1       = lowest_one(avail1);
        free_words = ~summary_reg;
        up_words   = free_words
                   & ~((word_t'(2) << host_reg[MAX_HOST_BITS-1:BIT_IDX_W]) - word_t'(1));
        cand_words = (!rsvd_reg && (up_words != '0)) ? up_words : free_words;
        pick_word  = WORD_IDX_W'(lowest_one(cand_words));
        bit2       = lowest_one(~ram_rd);
    end

    assign in_fire  = in_valid && !in_stall;
    assign fin_fire = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    // Free count after the pending update
    always_comb
    begin
        free_after = free_total_reg;
        if (pend_inc_reg)
        begin
            free_after = free_total_reg + COUNT_W'(1);
        end
        else if (pend_dec_reg && (free_total_reg != '0))
        begin
            free_after = free_total_reg - COUNT_W'(1);
        end
    end

    // Control and datapath next-state logic
    always_comb
    begin
        state_next       = state_reg;
        init_cnt_next    = init_cnt_reg;
        kind_next        = kind_reg;
        host_next        = host_reg;
        rsvd_next        = rsvd_reg;
        word2_next       = word2_reg;
        summary_next     = summary_reg;
        free_total_next  = free_total_reg;
        prefix_next      = prefix_reg;
        host_bits_next   = host_bits_reg;
        pend_we_next     = pend_we_reg;
        pend_word_next   = pend_word_reg;
        pend_data_next   = pend_data_reg;
        pend_inc_next    = pend_inc_reg;
        pend_dec_next    = pend_dec_reg;
        pend_status_next = pend_status_reg;
        pend_host_next   = pend_host_reg;
        out_valid_next   = out_valid_reg;
        out_addr_next    = out_addr_reg;
        out_status_next  = out_status_reg;
        out_free_next    = out_free_reg;
        ram_we           = 1'b0;
        ram_wa           = init_cnt_reg;
        ram_wd           = init_word;
        ram_re           = 1'b0;
        ram_ra           = in_host[MAX_HOST_BITS-1:BIT_IDX_W];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                ram_we = 1'b1;
                summary_next[init_cnt_reg] = &init_word;
                init_cnt_next = init_cnt_reg + WORD_IDX_W'(1);
                if (init_cnt_reg == WORD_IDX_W'(NUM_WORDS - 1))
                begin
                    free_total_next = pool_size - COUNT_W'(3);
                    state_next      = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ram_re     = 1'b1;
                    kind_next  = kind;
                    host_next  = in_host;
                    rsvd_next  = in_rsvd;
                    state_next = S_CHK1;
                end
            end
            S_CHK1:
            begin
                pend_we_next     = 1'b0;
                pend_inc_next    = 1'b0;
                pend_dec_next    = 1'b0;
                pend_status_next = ST_OK;
                pend_word_next   = host_reg[MAX_HOST_BITS-1:BIT_IDX_W];
                pend_host_next   = host_reg;
                state_next       = S_FIN;
                if (kind_reg == KIND_FREE)
                begin
                    if (rsvd_reg)
                    begin
                        pend_status_next = ST_RESERVED;
                    end
                    else if (!ram_rd[host_reg[BIT_IDX_W-1:0]])
                    begin
                        pend_status_next = ST_NOT_ALLOC;
                    end
                    else
                    begin
                        pend_we_next   = 1'b1;
                        pend_inc_next  = 1'b1;
                        pend_data_next = ram_rd & ~(word_t'(1) << host_reg[BIT_IDX_W-1:0]);
                    end
                end
                else if (!rsvd_reg && (avail1 != '0))
                begin
                    // free host in the preferred word at or above the preferred bit
                    pend_we_next   = 1'b1;
                    pend_dec_next  = 1'b1;
                    pend_data_next = ram_rd | (word_t'(1) << bit1);
                    pend_host_next = {host_reg[MAX_HOST_BITS-1:BIT_IDX_W], bit1};
                end
                else if (free_words == '0)
                begin
                    pend_status_next = ST_FULL;
                end
                else
                begin
                    // fetch the chosen word for a second look
                    ram_re     = 1'b1;
                    ram_ra     = pick_word;
                    word2_next = pick_word;
                    state_next = S_CHK2;
                end
            end
            S_CHK2:
            begin
                pend_we_next     = 1'b1;
                pend_dec_next    = 1'b1;
                pend_inc_next    = 1'b0;
                pend_status_next = ST_OK;
                pend_word_next   = word2_reg;
                pend_data_next   = ram_rd | (word_t'(1) << bit2);
                pend_host_next   = {word2_reg, bit2};
                state_next       = S_FIN;
            end
            S_FIN:
            begin
                if (fin_fire)
                begin
                    ram_we = pend_we_reg;
                    ram_wa = pend_word_reg;
                    ram_wd = pend_data_reg;
                    if (pend_we_reg)
                    begin
                        summary_next[pend_word_reg] = &pend_data_reg;
                    end
                    free_total_next = free_after;
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_free_next   = free_after;
                    if ((kind_reg == KIND_ALLOC) && (pend_status_reg == ST_OK))
                    begin
                        out_addr_next = prefix_reg | {{(32 - MAX_HOST_BITS){1'b0}}, pend_host_reg};
                    end
                    else
                    begin
                        out_addr_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        // Register writes; a new host bit count rebuilds the pool
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PREFIX:
                begin
                    prefix_next = cfg_data;
                end
                CFG_HOST_BITS:
                begin
                    host_bits_next = cfg_data[HB_W-1:0];
                    init_cnt_next  = '0;
                    state_next     = S_INIT;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            init_cnt_reg   <= '0;
            summary_reg    <= '1;
            free_total_reg <= FREE_RESET;
            prefix_reg     <= '0;
            host_bits_reg  <= HB_W'(MAX_HOST_BITS);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            init_cnt_reg   <= init_cnt_next;
            summary_reg    <= summary_next;
            free_total_reg <= free_total_next;
            prefix_reg     <= prefix_next;
            host_bits_reg  <= host_bits_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        host_reg        <= host_next;
        rsvd_reg        <= rsvd_next;
        word2_reg       <= word2_next;
        pend_we_reg     <= pend_we_next;
        pend_word_reg   <= pend_word_next;
        pend_data_reg   <= pend_data_next;
        pend_inc_reg    <= pend_inc_next;
        pend_dec_reg    <= pend_dec_next;
        pend_status_reg <= pend_status_next;
        pend_host_reg   <= pend_host_next;
        out_addr_reg    <= out_addr_next;
        out_status_reg  <= out_status_next;
        out_free_reg    <= out_free_next;
    end

    assign cfg_ready        = 1'b1;
    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign assigned_address = out_addr_reg;
    assign status           = out_status_reg;
    assign free_count       = out_free_reg;

    // The second word fetched was flagged as not full, so it must hold a free host
    a_chk2_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK2) |-> (ram_rd != '1))
        else $error("second search word has no free host");

    // Free count never exceeds the largest pool less its reserved hosts
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_total_reg <= FREE_RESET)
        else $error("free count out of range");

    // A result only appears after the write-back step
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result loaded outside write-back");

    // Failed items grant no address
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_OK)) |-> (out_addr_reg == '0))
        else $error("address reported with failing status");

endmodule
